// ----- rtl/dbpr_pkg.sv -----
`timescale 1ns / 1ps

package dbpr_pkg;

    // Input command codes.
    localparam logic CMD_BASELINE = 1'b0;
    localparam logic CMD_SCAN     = 1'b1;

    // Fixed widths of the result fields.
    localparam int SLOT_W   = 5;
    localparam int GPIO_W   = 6;
    localparam int BUTTON_W = 5;

    // Number of distinct table keys (slot index modulo 32).
    localparam int KEY_NUM = 32;

    // GPIO number of each candidate slot.
    localparam int GPIO_LIST_LEN = 25;
    localparam logic [GPIO_W-1:0] GPIO_OF_SLOT [GPIO_LIST_LEN] = '{
        6'd1,  6'd2,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10,
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd21,
        6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd47, 6'd48
    };

    // Per-cycle strobes from the input handshake to every lane.
    typedef struct packed {
        logic load;  // baseline transaction: capture level, clear time
        logic scan;  // scan transaction: evaluate the pin
    } lane_cmd_t;

    // One result transaction.
    typedef struct packed {
        logic [SLOT_W-1:0]   pin_slot;
        logic [GPIO_W-1:0]   gpio_number;
        logic [BUTTON_W-1:0] button_number;
        logic                is_repeat;
        logic                last_event;
    } evt_t;

    // GPIO number of a slot; slots past the candidate list report zero.
    function automatic logic [GPIO_W-1:0] gpio_for(input logic [5:0] slot);
        logic [GPIO_W-1:0] g;
        g = '0;
        if (slot < 6'(GPIO_LIST_LEN))
        begin
            g = GPIO_OF_SLOT[slot[4:0]];
        end
        return g;
    endfunction

endpackage

// ----- rtl/debounced_press_order_recorder.sv -----
`timescale 1ns / 1ps

// Debounced press order recorder.
// Scan channel (scan_valid / scan_stall): command, pin_levels, now_ms. A
// baseline transaction (command 0) loads every pin's level and clears its
// change time. A scan transaction (command 1) lets all pin lanes judge
// their level change at once, then a merge stage walks the pins in pin
// order, one pin per cycle unless stalled, assigning order table positions.
// Event channel (event_valid / event_stall): one transaction per reported
// press; last_event marks the final one of a scan. Each result is held back
// one step so the last can be marked. A scan keeps the block busy through
// the one-pin-per-cycle walk and the final flush, and longer while the
// receiver stalls; a baseline does not make it busy.
// scan_stall stays high while a scan is being walked. When the receiver
// stalls, the walk pauses once an event is both held in the output register
// and waiting behind it; nothing is dropped.
// Configuration: settle_ms is written when cfg_valid is high (cfg_ready is
// always high). Reset sets the interval to 25, all levels high, change times
// to zero and empties the order table.
module debounced_press_order_recorder #(
    parameter int NUM_PINS    = 25,
    parameter int TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         settle_ms,
    input  logic                scan_valid,
    output logic                scan_stall,
    input  logic                command,
    input  logic [NUM_PINS-1:0] pin_levels,
    input  logic [31:0]         now_ms,
    output logic                event_valid,
    input  logic                event_stall,
    output logic [4:0]          pin_slot,
    output logic [5:0]          gpio_number,
    output logic [4:0]          button_number,
    output logic                is_repeat,
    output logic                last_event
);

    logic [15:0]          debounce_reg;
    logic                 busy;
    logic                 accept;
    dbpr_pkg::lane_cmd_t  lane_cmd;
    logic [NUM_PINS-1:0]  press_mask;
    dbpr_pkg::evt_t       event_data;

    // Debounce interval register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= 16'd25;
        end
        else if (cfg_valid && cfg_ready)
        begin
            debounce_reg <= settle_ms;
        end
    end

    // Input transaction decode.
    assign scan_stall    = busy;
    assign accept        = scan_valid && !scan_stall;
    assign lane_cmd.load = accept && (command == dbpr_pkg::CMD_BASELINE);
    assign lane_cmd.scan = accept && (command == dbpr_pkg::CMD_SCAN);

    // One debounce lane per watched pin.
    for (genvar k = 0; k < NUM_PINS; k++)
    begin : g_lane
        dbpr_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (lane_cmd),
            .level     (pin_levels[k]),
            .now_ms    (now_ms),
            .settle_ms (debounce_reg),
            .press     (press_mask[k])
        );
    end

    // Ordered merge of the presses and the order table.
    dbpr_merge #(
        .NUM_PINS    (NUM_PINS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (lane_cmd.scan),
        .press_mask  (press_mask),
        .busy        (busy),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_data  (event_data)
    );

    assign pin_slot      = event_data.pin_slot;
    assign gpio_number   = event_data.gpio_number;
    assign button_number = event_data.button_number;
    assign is_repeat     = event_data.is_repeat;
    assign last_event    = event_data.last_event;

endmodule

// ----- rtl/dbpr_lane.sv -----
`timescale 1ns / 1ps

module dbpr_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  dbpr_pkg::lane_cmd_t cmd,
    input  logic               level,
    input  logic [31:0]        now_ms,
    input  logic [15:0]        settle_ms,
    output logic               press
);

    logic        acc_level_reg;
    logic        acc_level_next;
    logic [31:0] change_time_reg;
    logic [31:0] change_time_next;
    logic [31:0] elapsed;
    logic        accept;

    // A change is taken once the debounce interval has passed (mod 2^32).
    assign elapsed = now_ms - change_time_reg;
    assign accept  = (level != acc_level_reg) && (elapsed >= {16'd0, settle_ms});
    assign press   = cmd.scan && accept && !level;

    // Next state of the pin's accepted level and change time.
    always_comb
    begin
        acc_level_next   = acc_level_reg;
        change_time_next = change_time_reg;
        if (cmd.load)
        begin
            acc_level_next   = level;
            change_time_next = '0;
        end
        else if (cmd.scan && accept)
        begin
            acc_level_next   = level;
            change_time_next = now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_level_reg   <= 1'b1;
            change_time_reg <= '0;
        end
        else
        begin
            acc_level_reg   <= acc_level_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

// ----- rtl/dbpr_merge.sv -----
`timescale 1ns / 1ps

module dbpr_merge #(
    parameter int NUM_PINS    = 25,
    parameter int TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_PINS-1:0] press_mask,
    output logic                busy,
    output logic                event_valid,
    input  logic                event_stall,
    output dbpr_pkg::evt_t      event_data
);

    localparam int IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam int POS_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [NUM_PINS-1:0] mask_reg;
    logic [NUM_PINS-1:0] mask_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    // Reverse map of the order table: key is the slot modulo 32.
    logic [dbpr_pkg::KEY_NUM-1:0] mapped_reg;
    logic [dbpr_pkg::KEY_NUM-1:0] mapped_next;
    logic [POS_W-1:0]             pos_reg [dbpr_pkg::KEY_NUM];
    logic                         pos_we;

    logic           pend_valid_reg;
    logic           pend_valid_next;
    dbpr_pkg::evt_t pend_reg;
    dbpr_pkg::evt_t pend_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    dbpr_pkg::evt_t out_reg;
    dbpr_pkg::evt_t out_next;

    logic [5:0]     slot6;
    logic [4:0]     key;
    logic           seen;
    logic           room;
    logic           has_res;
    logic           out_free;
    logic           last_idx;
    dbpr_pkg::evt_t cand;

    // Decode the pin under the walk pointer.
    assign slot6    = 6'(idx_reg);
    assign key      = slot6[4:0];
    assign seen     = mapped_reg[key];
    assign room     = count_reg < CNT_W'(TABLE_DEPTH);
    assign has_res  = mask_reg[idx_reg] && (seen || room);
    assign out_free = !out_valid_reg || !event_stall;
    assign last_idx = (idx_reg == IDX_W'(NUM_PINS - 1));

    always_comb
    begin
        cand.pin_slot      = key;
        cand.gpio_number   = dbpr_pkg::gpio_for(slot6);
        cand.button_number = seen ? dbpr_pkg::BUTTON_W'(pos_reg[key])
                                  : dbpr_pkg::BUTTON_W'(count_reg);
        cand.is_repeat     = seen;
        cand.last_event    = 1'b0;
    end

    // Walk sequencer: one pin per cycle unless the output stalls, one result held back to mark the last.
    always_comb
    begin
        state_next      = state_reg;
        mask_next       = mask_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        mapped_next     = mapped_reg;
        pos_we          = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && event_stall;
        out_next        = out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mask_next  = press_mask;
                    idx_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!(has_res && pend_valid_reg && !out_free))
                begin
                    if (has_res)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = cand;
                        if (!seen)
                        begin
                            mapped_next[key] = 1'b1;
                            pos_we           = 1'b1;
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end
                    if (last_idx)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = pend_reg;
                    out_next.last_event  = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            mapped_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            mapped_reg     <= mapped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        idx_reg  <= idx_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        if (pos_we)
        begin
            pos_reg[key] <= POS_W'(count_reg);
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign event_valid = out_valid_reg;
    assign event_data  = out_reg;

endmodule

// ----- verif/debounced_press_order_recorder_test.sv -----
`timescale 1ns / 1ps

module debounced_press_order_recorder_test;

    localparam int PIN_COUNT     = 25;
    localparam int ORDER_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP       = 40;

    // GPIO number behind each watched slot.
    localparam int SLOT_GPIO_LEN = 25;
    localparam logic [5:0] SLOT_GPIO [SLOT_GPIO_LEN] = '{
        6'd1,  6'd2,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,  6'd10,
        6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd21,
        6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd47, 6'd48
    };

    localparam logic [PIN_COUNT-1:0] ALL_HIGH = '1;
    localparam logic [PIN_COUNT-1:0] ALL_LOW  = '0;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [15:0]          settle_ms = '0;
    logic                 scan_valid = 1'b0;
    logic                 scan_stall;
    logic                 command = dbpr_pkg::CMD_BASELINE;
    logic [PIN_COUNT-1:0] pin_levels = '1;
    logic [31:0]          now_ms = '0;
    logic                 event_valid;
    logic                 event_stall = 1'b0;
    logic [4:0]           pin_slot;
    logic [5:0]           gpio_number;
    logic [4:0]           button_number;
    logic                 is_repeat;
    logic                 last_event;

    // Mirror of the block's state, advanced on every accepted scan transaction.
    logic [PIN_COUNT-1:0] pin_level_q;
    logic [31:0]          pin_change_ms [PIN_COUNT];
    logic [4:0]           press_order [ORDER_DEPTH];
    int                   press_count;
    logic [15:0]          debounce_cur;

    dbpr_pkg::evt_t expected_presses[$];
    dbpr_pkg::evt_t want_evt;

    int tx_idle_pct = 22;
    int rx_idle_pct = 83;
    int err_cnt = 0;
    int items_sent = 0;
    int events_seen = 0;
    int cfg_writes = 0;

    // Stimulus history used to build well-formed press and release sequences.
    logic [PIN_COUNT-1:0] stim_levels;
    logic [31:0]          stim_time;

    debounced_press_order_recorder #(
        .NUM_PINS    (PIN_COUNT),
        .TABLE_DEPTH (ORDER_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .settle_ms     (settle_ms),
        .scan_valid    (scan_valid),
        .scan_stall    (scan_stall),
        .command       (command),
        .pin_levels    (pin_levels),
        .now_ms        (now_ms),
        .event_valid   (event_valid),
        .event_stall   (event_stall),
        .pin_slot      (pin_slot),
        .gpio_number   (gpio_number),
        .button_number (button_number),
        .is_repeat     (is_repeat),
        .last_event    (last_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        event_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Compare every event transaction with the oldest predicted press.
    always @(posedge clk)
    begin
        if (rst_n && event_valid && !event_stall)
        begin
            events_seen++;
            if (expected_presses.size() == 0)
            begin
                $error("unexpected event: slot %0d gpio %0d button %0d",
                       pin_slot, gpio_number, button_number);
                err_cnt++;
            end
            else
            begin
                want_evt = expected_presses.pop_front();
                if (pin_slot !== want_evt.pin_slot)
                begin
                    $error("pin_slot: expected %0d, got %0d", want_evt.pin_slot, pin_slot);
                    err_cnt++;
                end
                if (gpio_number !== want_evt.gpio_number)
                begin
                    $error("gpio_number: expected %0d, got %0d",
                           want_evt.gpio_number, gpio_number);
                    err_cnt++;
                end
                if (button_number !== want_evt.button_number)
                begin
                    $error("button_number: expected %0d, got %0d",
                           want_evt.button_number, button_number);
                    err_cnt++;
                end
                if (is_repeat !== want_evt.is_repeat)
                begin
                    $error("is_repeat: expected %0d, got %0d", want_evt.is_repeat, is_repeat);
                    err_cnt++;
                end
                if (last_event !== want_evt.last_event)
                begin
                    $error("last_event: expected %0d, got %0d",
                           want_evt.last_event, last_event);
                    err_cnt++;
                end
            end
        end
    end

    function automatic void reset_press_mirror();
        pin_level_q  = '1;
        press_count  = 0;
        debounce_cur = 16'd25;
        for (int s = 0; s < PIN_COUNT; s++)
        begin
            pin_change_ms[s] = '0;
        end
    endfunction

    // Work out the presses reported for one accepted scan transaction.
    function automatic void predict_presses(input logic cmd, input logic [PIN_COUNT-1:0] lv,
                                            input logic [31:0] t);
        dbpr_pkg::evt_t batch[$];
        dbpr_pkg::evt_t ev;
        int             pos;
        logic [31:0]    since;
        if (cmd == dbpr_pkg::CMD_BASELINE)
        begin
            for (int s = 0; s < PIN_COUNT; s++)
            begin
                pin_level_q[s]   = lv[s];
                pin_change_ms[s] = '0;
            end
            return;
        end
        for (int s = 0; s < PIN_COUNT; s++)
        begin
            since = t - pin_change_ms[s];
            if (lv[s] == pin_level_q[s] || since < {16'h0, debounce_cur})
            begin
                continue;
            end
            pin_change_ms[s] = t;
            pin_level_q[s]   = lv[s];
            // A release only moves the state.
            if (lv[s])
            begin
                continue;
            end
            pos = -1;
            for (int j = 0; j < press_count; j++)
            begin
                if (pos < 0 && press_order[j] == 5'(s))
                begin
                    pos = j;
                end
            end
            ev.pin_slot    = 5'(s);
            ev.gpio_number = (s < SLOT_GPIO_LEN) ? SLOT_GPIO[s] : 6'd0;
            ev.last_event  = 1'b0;
            if (pos >= 0)
            begin
                ev.button_number = 5'(pos);
                ev.is_repeat     = 1'b1;
            end
            else if (press_count < ORDER_DEPTH)
            begin
                ev.button_number = 5'(press_count);
                ev.is_repeat     = 1'b0;
                press_order[press_count] = 5'(s);
                press_count++;
            end
            else
            begin
                // Order table full: the new pin is dropped.
                continue;
            end
            batch.push_back(ev);
        end
        if (batch.size() > 0)
        begin
            batch[batch.size()-1].last_event = 1'b1;
        end
        foreach (batch[i])
        begin
            expected_presses.push_back(batch[i]);
        end
    endfunction

    // Offer one scan transaction and hold it until the block takes it.
    task automatic send_scan(input logic cmd, input logic [PIN_COUNT-1:0] lv,
                             input logic [31:0] t);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_valid <= 1'b1;
        command    <= cmd;
        pin_levels <= lv;
        now_ms     <= t;
        do
            @(posedge clk);
        while (!(scan_valid && !scan_stall));
        predict_presses(cmd, lv, t);
        items_sent++;
    endtask

    // Stop sending and let every predicted press come out, then let the walk finish.
    task automatic hold_until_drained();
        scan_valid <= 1'b0;
        while (expected_presses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [15:0] value);
        cfg_valid <= 1'b1;
        settle_ms <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid    <= 1'b0;
        debounce_cur = value;
        cfg_writes++;
    endtask

    // Default interval of 25 ms: a change just too early is ignored, one at the limit counts.
    task automatic test_reset_default_debounce();
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH & ~25'h1, 32'd10);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH & ~25'h1, 32'd25);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH & ~25'h1 & ~(25'h1 << 24), 32'd26);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH, 32'd40);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH, 32'd60);
        hold_until_drained();
    endtask

    // With no debounce every pin reacts at once: full scans give the most events.
    task automatic test_all_pins_zero_debounce();
        write_debounce(16'd0);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_LOW, 32'd100);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH, 32'd100);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_LOW, 32'd100);
        send_scan(dbpr_pkg::CMD_SCAN, 25'h0AAAAAA, 32'd101);
        send_scan(dbpr_pkg::CMD_SCAN, 25'h1555555, 32'd102);
        hold_until_drained();
    endtask

    // Baseline keeps the order table; elapsed time is measured across the wrap.
    task automatic test_baseline_and_time_wrap();
        write_debounce(16'd100);
        send_scan(dbpr_pkg::CMD_BASELINE, ALL_LOW, 32'h1234_5678);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH, 32'hFFFF_FFF0);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_LOW, 32'h0000_0010);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_LOW, 32'h0000_0060);
        send_scan(dbpr_pkg::CMD_BASELINE, ALL_HIGH, 32'hFFFF_FFFF);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH & ~25'h1, 32'hFFFF_FFFF);
        hold_until_drained();
    endtask

    task automatic test_max_debounce();
        write_debounce(16'hFFFF);
        send_scan(dbpr_pkg::CMD_BASELINE, ALL_HIGH, 32'd0);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH & ~(25'h1 << 5), 32'd65534);
        send_scan(dbpr_pkg::CMD_SCAN, ALL_HIGH & ~(25'h1 << 5), 32'd65535);
        hold_until_drained();
    endtask

    // Mostly a few pins toggling with time stepping around the interval, some noise.
    task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                    input logic [15:0] interval, input int count);
        int                   pick;
        logic [PIN_COUNT-1:0] flips;
        logic                 cmd;
        hold_until_drained();
        write_debounce(interval);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            cmd  = dbpr_pkg::CMD_SCAN;
            if (pick < 6)
            begin
                cmd         = dbpr_pkg::CMD_BASELINE;
                stim_levels = PIN_COUNT'($urandom);
            end
            else if (pick < 14)
            begin
                stim_levels = PIN_COUNT'($urandom);
            end
            else
            begin
                flips = '0;
                repeat ($urandom_range(1, 4))
                begin
                    flips[$urandom_range(PIN_COUNT - 1)] = 1'b1;
                end
                stim_levels = stim_levels ^ flips;
            end
            if ($urandom_range(99) < 8)
            begin
                stim_time = $urandom;
            end
            else
            begin
                stim_time = stim_time + 32'($urandom_range(0, 2 * int'(interval) + 3));
            end
            send_scan(cmd, stim_levels, stim_time);
        end
    endtask

    task automatic test_random_traffic();
        stim_levels = ALL_HIGH;
        stim_time   = 32'd200_000;
        run_random_phase(22, 83, 16'd0, 40);
        run_random_phase(22, 83, 16'hFFFF, 38);
        run_random_phase(83, 22, 16'($urandom_range(1, 60)), 40);
        run_random_phase(83, 22, 16'd25, 38);
        run_random_phase(0, 0, 16'd1, 38);
        run_random_phase(0, 0, 16'($urandom), 38);
        hold_until_drained();
    endtask

    initial
    begin
        reset_press_mirror();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_default_debounce();
        test_all_pins_zero_debounce();
        test_baseline_and_time_wrap();
        test_max_debounce();
        test_random_traffic();

        $display("Run covered %0d scan transactions and %0d press events",
                 items_sent, events_seen);
        $display("over %0d debounce settings, with sender and receiver idling swapped %s",
                 cfg_writes, "between phases and a phase with no idling.");
        if (err_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
